// ===== src/frls_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types for the record log.
package frls_pkg;

   localparam int SECTOR_WORDS = 4096;
   localparam int ADDR_W       = $clog2(SECTOR_WORDS);
   localparam int WORD_W       = 32;
   localparam int ID_W         = 31;
   localparam int SLOT_W       = 12;
   localparam int CMD_W        = 2;

   localparam int REQ_FIELDS_W = CMD_W + ID_W;
   localparam int REQ_W        = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = ID_W + 2 + SLOT_W;
   localparam int RSP_W        = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(SECTOR_WORDS - 1);
   localparam logic [WORD_W-1:0] ERASED_WORD  = '1;
   localparam logic [WORD_W-1:0] CLEARED_WORD = '0;
   localparam logic [WORD_W-1:0] RECORD_MARK  = 32'h8000_0000;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ERASE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_WIPE,
      ST_STORE0,
      ST_STORE1,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      WSEL_ERASED,
      WSEL_CLEARED,
      WSEL_RECORD
   } wsel_type;

   typedef struct packed {
      logic     latch;
      logic     ptr_clr;
      logic     ptr_inc;
      logic     issue;
      logic     mem_we;
      wsel_type wsel;
      logic     read_hit;
      logic     write_hit;
      logic     set_wiped;
      logic     set_record_slot;
      logic     load_out;
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             tst_vld;
      logic             tst_top;
      logic             tst_last;
      logic             ptr_last;
      logic             out_busy;
   } status_type;

endpackage

// ===== src/frls_datapath.sv =====
// Sector memory, scan pointer, read test pipeline, result and output registers.
module frls_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  frls_pkg::cmd_type           cmd,
   output frls_pkg::status_type        status,
   input  logic [frls_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [frls_pkg::RSP_W-1:0]  rsp_tdata
);

   localparam int AW    = frls_pkg::ADDR_W;
   localparam int WW    = frls_pkg::WORD_W;
   localparam int IW    = frls_pkg::ID_W;
   localparam int SW    = frls_pkg::SLOT_W;
   localparam int CW    = frls_pkg::CMD_W;
   localparam int PAD_W = frls_pkg::RSP_W - frls_pkg::RSP_FIELDS_W;

   logic [WW-1:0] mem [frls_pkg::SECTOR_WORDS];

   logic [AW-1:0] ptr_ff, ptr_in;
   logic          vld_ff;
   logic [WW-1:0] rd_data_ff;
   logic [AW-1:0] idx_ff;
   logic [CW-1:0] command_ff;
   logic [IW-1:0] new_id_ff;
   logic [IW-1:0] cur_ff;
   logic          found_ff;
   logic          wiped_ff;
   logic [SW-1:0] slot_ff;
   logic [AW-1:0] hit_ff;
   logic [AW-1:0] hit_next;
   logic          rsp_valid_ff;
   logic [frls_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic [AW-1:0] waddr;
   logic [WW-1:0] wdata;

   assign hit_next = hit_ff + AW'(1);

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_clr) begin
         ptr_in = '0;
      end else if (cmd.ptr_inc && ptr_ff != frls_pkg::LAST_ADDR) begin
         ptr_in = ptr_ff + AW'(1);
      end
   end

   always_comb begin
      case (cmd.wsel)
         frls_pkg::WSEL_ERASED: begin
            waddr = ptr_ff;
            wdata = frls_pkg::ERASED_WORD;
         end
         frls_pkg::WSEL_CLEARED: begin
            waddr = hit_ff;
            wdata = frls_pkg::CLEARED_WORD;
         end
         frls_pkg::WSEL_RECORD: begin
            waddr = hit_next;
            wdata = frls_pkg::RECORD_MARK | {1'b0, new_id_ff};
         end
         default: begin
            waddr = ptr_ff;
            wdata = frls_pkg::ERASED_WORD;
         end
      endcase
   end

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[ptr_ff];
      idx_ff     <= ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff <= ptr_in;
         vld_ff <= cmd.issue;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         command_ff <= req_tdata[CW-1:0];
         new_id_ff  <= req_tdata[CW+IW-1:CW];
         cur_ff     <= '0;
         found_ff   <= 1'b0;
         wiped_ff   <= 1'b0;
         slot_ff    <= '0;
      end else begin
         if (cmd.read_hit) begin
            cur_ff   <= rd_data_ff[IW-1:0];
            found_ff <= 1'b1;
            slot_ff  <= SW'(idx_ff);
         end
         if (cmd.write_hit) begin
            hit_ff <= idx_ff;
         end
         if (cmd.set_wiped) begin
            wiped_ff <= 1'b1;
         end
         if (cmd.set_record_slot) begin
            slot_ff <= SW'(hit_next);
         end
      end
   end

   assign rsp_data_in = {{PAD_W{1'b0}}, slot_ff, wiped_ff, found_ff, cur_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.command  = command_ff;
   assign status.tst_vld  = vld_ff;
   assign status.tst_top  = rd_data_ff[WW-1];
   assign status.tst_last = (idx_ff == frls_pkg::LAST_ADDR);
   assign status.ptr_last = (ptr_ff == frls_pkg::LAST_ADDR);
   assign status.out_busy = rsp_valid_ff & ~rsp_tready;

endmodule

// ===== src/frls_ctrl.sv =====
// Controller state machine: clearing pass, command dispatch, scan, sector wipe and record store.
module frls_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  frls_pkg::status_type  status,
   output frls_pkg::cmd_type     cmd
);

   frls_pkg::state_type state_ff, state_in;
   logic                is_write;

   assign is_write = (status.command == frls_pkg::CMD_WRITE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frls_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         frls_pkg::ST_CLEAR: begin
            if (status.ptr_last) state_in = frls_pkg::ST_IDLE;
         end
         frls_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = frls_pkg::ST_DISPATCH;
         end
         frls_pkg::ST_DISPATCH: begin
            case (status.command)
               frls_pkg::CMD_WRITE: state_in = frls_pkg::ST_SCAN;
               frls_pkg::CMD_READ:  state_in = frls_pkg::ST_SCAN;
               frls_pkg::CMD_ERASE: state_in = frls_pkg::ST_WIPE;
               default:             state_in = frls_pkg::ST_FINISH;
            endcase
         end
         frls_pkg::ST_SCAN: begin
            if (status.tst_vld) begin
               if (is_write) begin
                  // last word is never tested on a write: wipe and rescan
                  if (status.tst_last)     state_in = frls_pkg::ST_WIPE;
                  else if (status.tst_top) state_in = frls_pkg::ST_STORE0;
               end else if (status.tst_top || status.tst_last) begin
                  state_in = frls_pkg::ST_FINISH;
               end
            end
         end
         frls_pkg::ST_WIPE: begin
            if (status.ptr_last) begin
               state_in = is_write ? frls_pkg::ST_SCAN : frls_pkg::ST_FINISH;
            end
         end
         frls_pkg::ST_STORE0: state_in = frls_pkg::ST_STORE1;
         frls_pkg::ST_STORE1: state_in = frls_pkg::ST_FINISH;
         frls_pkg::ST_FINISH: begin
            if (!status.out_busy) state_in = frls_pkg::ST_IDLE;
         end
         default: state_in = frls_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.wsel   = frls_pkg::WSEL_ERASED;
      req_tready = 1'b0;
      case (state_ff)
         frls_pkg::ST_CLEAR: begin
            cmd.mem_we  = 1'b1;
            cmd.ptr_inc = 1'b1;
         end
         frls_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.ptr_clr = 1'b1;
            cmd.latch   = req_tvalid;
         end
         frls_pkg::ST_DISPATCH: begin
            cmd.set_wiped = (status.command == frls_pkg::CMD_ERASE);
         end
         frls_pkg::ST_SCAN: begin
            cmd.issue   = 1'b1;
            cmd.ptr_inc = 1'b1;
            if (status.tst_vld) begin
               if (is_write) begin
                  if (status.tst_last) begin
                     cmd.set_wiped = 1'b1;
                     cmd.ptr_clr   = 1'b1;
                  end else if (status.tst_top) begin
                     cmd.write_hit = 1'b1;
                  end
               end else if (status.tst_top) begin
                  cmd.read_hit = 1'b1;
               end
            end
         end
         frls_pkg::ST_WIPE: begin
            cmd.mem_we  = 1'b1;
            cmd.ptr_inc = 1'b1;
            cmd.ptr_clr = status.ptr_last;
         end
         frls_pkg::ST_STORE0: begin
            cmd.mem_we = 1'b1;
            cmd.wsel   = frls_pkg::WSEL_CLEARED;
         end
         frls_pkg::ST_STORE1: begin
            cmd.mem_we          = 1'b1;
            cmd.wsel            = frls_pkg::WSEL_RECORD;
            cmd.set_record_slot = 1'b1;
         end
         frls_pkg::ST_FINISH: begin
            cmd.load_out = ~status.out_busy;
         end
         default: begin
            cmd.ptr_clr = 1'b1;
         end
      endcase
   end

endmodule

// ===== src/flash_record_log_store_core.sv =====
// Record log store: one 31-bit id kept as an append-only log in a 4096-word sector memory.
// One command is taken at a time. After reset a clearing pass writes the sector to all ones
// with req_tready low. A read or write scans the memory one word per cycle through its single
// registered read port; a write then uses the memory's single write port to clear the old
// record and store the new one. An erase sweeps the whole sector; a write that reaches the
// last word sweeps it first and rescans. The result beat sits in an output register; the
// next command can be taken while it waits.
module flash_record_log_store_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [1:0] command, [32:2] new_id, [39:33] zero
   input  logic [frls_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [30:0] current_id, [31] found, [32] wiped, [44:33] slot, [47:45] zero
   output logic [frls_pkg::RSP_W-1:0]  rsp_tdata
);

   frls_pkg::cmd_type    cmd;
   frls_pkg::status_type status;

   frls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   frls_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== src/frls_checker.sv =====
// Port-level checks for the record log store, bound to the top level.
module frls_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [frls_pkg::RSP_W-1:0]  rsp_tdata
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // one command in flight
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command taken while another is in flight");

   // clearing pass keeps the input closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input open during clearing pass");

   // no record found means no id
   a_not_found_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[31] |-> rsp_tdata[30:0] == '0)
      else $error("id reported without a found record");

   // a read never wipes
   a_found_not_wiped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31] |-> !rsp_tdata[32])
      else $error("found and wiped in the same beat");

endmodule

bind flash_record_log_store_core frls_checker u_frls_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
